// File: sv/vertex_4d_to_3d_projection_unit_defines.svh
// Assertion macros shared by the 4D-to-3D projection RTL.
// Depends on nothing; expects clk_i and rst_ni in the including module.
`ifndef VERTEX_4D_TO_3D_PROJECTION_UNIT_DEFINES_SVH
`define VERTEX_4D_TO_3D_PROJECTION_UNIT_DEFINES_SVH

// checked only while out of reset
`define VP4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vp4 assertion failed");

// checked also during reset
`define VP4_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("vp4 assertion failed (always)");

`endif

// File: sv/vp4_pkg.sv
// Shared constants and helpers for the 4D-to-3D projection unit.
// No dependencies.
package vp4_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DenW   = 34;   // signed denominator, exact
  localparam int unsigned NumMagW = 63;  // |coord * param| <= 2^62
  localparam int unsigned QBits  = 33;   // quotient bits resolved by the divider
  localparam int unsigned RemW   = DenW + 1;
  localparam int unsigned DivLat = QBits + 2;

  localparam logic [1:0] ModePersp  = 2'd0;
  localparam logic [1:0] ModeStereo = 2'd1;
  localparam logic [1:0] ModeOrtho  = 2'd2;
  localparam logic [1:0] ModeOblq   = 2'd3;

  localparam logic       CfgIdxMode  = 1'b0;
  localparam logic       CfgIdxParam = 1'b1;

  localparam logic signed [31:0] QOne       = 32'sd65536;
  localparam logic signed [31:0] ParamReset = 32'sd131072;

  function automatic logic [31:0] sat49(input logic signed [48:0] v);
    logic [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: sv/vp4_div.sv
// Pipelined unsigned long divider with signed saturating result, one
// quotient bit per stage. Depends on vp4_pkg and the defines header.
`include "vertex_4d_to_3d_projection_unit_defines.svh"

module vp4_div
  import vp4_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [NumMagW-1:0]  num_i,
  input  logic [DenW-1:0]     den_i,
  input  logic                neg_i,
  output logic [CoordW-1:0]   q_o
);

  logic [RemW-1:0]   rem_q [0:QBits];
  logic [QBits-1:0]  quo_q [0:QBits];
  logic [QBits-1:0]  nb_q  [0:QBits];
  logic [DenW-1:0]   den_q [0:QBits];
  logic              ovf_q [0:QBits];
  logic              neg_q [0:QBits];
  logic [CoordW-1:0] q_q;

  // head: overflow check, remainder seeded with the numerator's top bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= ({4'd0, num_i[NumMagW-1:QBits]} >= den_i);
      rem_q[0] <= {5'd0, num_i[NumMagW-1:QBits]};
      nb_q[0]  <= num_i[QBits-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= QBits; k++) begin : g_step
    logic [RemW-1:0] t;
    logic            ge;
    assign t  = {rem_q[k-1][RemW-2:0], nb_q[k-1][QBits-1]};
    assign ge = (t >= {1'b0, den_q[k-1]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (t - {1'b0, den_q[k-1]}) : t;
        quo_q[k] <= {quo_q[k-1][QBits-2:0], ge};
        nb_q[k]  <= {nb_q[k-1][QBits-2:0], 1'b0};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [QBits-1:0]  qm;
  logic [CoordW-1:0] q_d;
  assign qm = quo_q[QBits];

  always_comb begin
    if (neg_q[QBits]) begin
      if (ovf_q[QBits] || qm > {1'b0, 32'h8000_0000}) begin
        q_d = 32'h8000_0000;
      end else begin
        q_d = 32'(-qm);
      end
    end else begin
      if (ovf_q[QBits] || qm[QBits-1:QBits-2] != 2'b00) begin
        q_d = 32'h7fff_ffff;
      end else begin
        q_d = qm[CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

  `VP4_ASSERT(a_den_moves, en_i |=> (den_q[1] === $past(den_q[0])))
  `VP4_ASSERT(a_ovf_moves, en_i |=> (ovf_q[QBits] === $past(ovf_q[QBits-1])))
  `VP4_ASSERT(a_hold_when_stalled, !en_i |=> $stable(q_q))

endmodule

// File: sv/vertex_4d_to_3d_projection_unit.sv
// Throughput one vertex per cycle while the output is not stalled, set by the
// 35-stage divider (a head stage, one quotient bit a stage, then an output register).
// The whole pipeline advances when the output register is empty or taken.
// Reset (async, active low) clears valid bits, mode to perspective and
// param to 2.0; payload registers are not reset.
// Depends on vp4_pkg, vp4_div and the defines header.
`include "vertex_4d_to_3d_projection_unit_defines.svh"

module vertex_4d_to_3d_projection_unit
  import vp4_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // in_x, in_y, in_z, in_w
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [95:0]  m_axis_tdata_o,  // out_x, out_y, out_z
  output logic         m_axis_tlast_o
);

  logic [1:0]         mode_q;
  logic signed [31:0] param_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModePersp;
      param_q <= ParamReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxMode:  mode_q  <= cfg_wdata_i[1:0];
        CfgIdxParam: param_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic out_valid_q;
  logic pipe_en;
  assign pipe_en         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = pipe_en;

  // stage 1: capture
  logic               st1_valid_q, st1_last_q;
  logic signed [31:0] st1_x_q, st1_y_q, st1_z_q, st1_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_valid_q <= 1'b0;
    end else if (pipe_en) begin
      st1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st1_x_q    <= s_axis_tdata_i[31:0];
      st1_y_q    <= s_axis_tdata_i[63:32];
      st1_z_q    <= s_axis_tdata_i[95:64];
      st1_w_q    <= s_axis_tdata_i[127:96];
      st1_last_q <= s_axis_tlast_i;
    end
  end

  // stage 2: denominator and products
  logic signed [DenW-1:0] den_d;
  logic signed [31:0]     mul_p;
  always_comb begin
    if (mode_q == ModePersp) begin
      den_d = DenW'(param_q) - DenW'(st1_w_q);
      mul_p = param_q;
    end else begin
      den_d = DenW'(QOne) - DenW'(st1_w_q);
      mul_p = QOne;
    end
    if (den_d == '0) begin
      den_d = DenW'(1);
    end
  end

  logic                   st2_valid_q, st2_last_q;
  logic [1:0]             st2_mode_q;
  logic signed [63:0]     st2_nx_q, st2_ny_q, st2_nz_q, st2_pw_q;
  logic signed [DenW-1:0] st2_den_q;
  logic signed [31:0]     st2_x_q, st2_y_q, st2_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_valid_q <= 1'b0;
    end else if (pipe_en) begin
      st2_valid_q <= st1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st2_last_q <= st1_last_q;
      st2_mode_q <= mode_q;
      st2_nx_q   <= st1_x_q * mul_p;
      st2_ny_q   <= st1_y_q * mul_p;
      st2_nz_q   <= st1_z_q * mul_p;
      st2_pw_q   <= param_q * st1_w_q;
      st2_den_q  <= den_d;
      st2_x_q    <= st1_x_q;
      st2_y_q    <= st1_y_q;
      st2_z_q    <= st1_z_q;
    end
  end

  // stage 3: magnitudes for the dividers, direct results for the other modes
  logic signed [47:0] shear;
  logic [31:0]        dx_d, dy_d;
  logic [63:0]        mx, my, mz;
  logic [DenW-1:0]    mden;
  assign shear = st2_pw_q[63:16];  // arithmetic floor of p*w / 2^16
  assign mx    = st2_nx_q[63] ? 64'(-st2_nx_q) : st2_nx_q;
  assign my    = st2_ny_q[63] ? 64'(-st2_ny_q) : st2_ny_q;
  assign mz    = st2_nz_q[63] ? 64'(-st2_nz_q) : st2_nz_q;
  assign mden  = st2_den_q[DenW-1] ? DenW'(-st2_den_q) : st2_den_q;

  always_comb begin
    if (st2_mode_q == ModeOblq) begin
      dx_d = sat49(49'(st2_x_q) + 49'(shear));
      dy_d = sat49(49'(st2_y_q) + 49'(shear));
    end else begin
      dx_d = st2_x_q;
      dy_d = st2_y_q;
    end
  end

  logic                st3_valid_q, st3_last_q, st3_div_q;
  logic [NumMagW-1:0]  st3_mx_q, st3_my_q, st3_mz_q;
  logic [DenW-1:0]     st3_den_q;
  logic                st3_nx_q, st3_ny_q, st3_nz_q;
  logic [31:0]         st3_dx_q, st3_dy_q, st3_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st3_valid_q <= 1'b0;
    end else if (pipe_en) begin
      st3_valid_q <= st2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st3_last_q <= st2_last_q;
      st3_div_q  <= (st2_mode_q == ModePersp) || (st2_mode_q == ModeStereo);
      st3_mx_q   <= mx[NumMagW-1:0];
      st3_my_q   <= my[NumMagW-1:0];
      st3_mz_q   <= mz[NumMagW-1:0];
      st3_den_q  <= mden;
      st3_nx_q   <= st2_nx_q[63] ^ st2_den_q[DenW-1];
      st3_ny_q   <= st2_ny_q[63] ^ st2_den_q[DenW-1];
      st3_nz_q   <= st2_nz_q[63] ^ st2_den_q[DenW-1];
      st3_dx_q   <= dx_d;
      st3_dy_q   <= dy_d;
      st3_dz_q   <= st2_z_q;
    end
  end

  logic [31:0] qx, qy, qz;

  vp4_div u_div_x (
    .clk_i, .rst_ni, .en_i(pipe_en),
    .num_i(st3_mx_q), .den_i(st3_den_q), .neg_i(st3_nx_q), .q_o(qx)
  );
  vp4_div u_div_y (
    .clk_i, .rst_ni, .en_i(pipe_en),
    .num_i(st3_my_q), .den_i(st3_den_q), .neg_i(st3_ny_q), .q_o(qy)
  );
  vp4_div u_div_z (
    .clk_i, .rst_ni, .en_i(pipe_en),
    .num_i(st3_mz_q), .den_i(st3_den_q), .neg_i(st3_nz_q), .q_o(qz)
  );

  // side band kept in step with the dividers
  logic        sb_valid_q [0:DivLat-1];
  logic        sb_last_q  [0:DivLat-1];
  logic        sb_div_q   [0:DivLat-1];
  logic [95:0] sb_dat_q   [0:DivLat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) begin
        sb_valid_q[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      sb_valid_q[0] <= st3_valid_q;
      for (int i = 1; i < DivLat; i++) begin
        sb_valid_q[i] <= sb_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sb_last_q[0] <= st3_last_q;
      sb_div_q[0]  <= st3_div_q;
      sb_dat_q[0]  <= {st3_dz_q, st3_dy_q, st3_dx_q};
      for (int i = 1; i < DivLat; i++) begin
        sb_last_q[i] <= sb_last_q[i-1];
        sb_div_q[i]  <= sb_div_q[i-1];
        sb_dat_q[i]  <= sb_dat_q[i-1];
      end
    end
  end

  logic [95:0] out_dat_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= sb_valid_q[DivLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_last_q <= sb_last_q[DivLat-1];
      out_dat_q  <= sb_div_q[DivLat-1] ? {qz, qy, qx} : sb_dat_q[DivLat-1];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_dat_q;
  assign m_axis_tlast_o  = out_last_q;

  `VP4_ASSERT(a_accept_reaches_st1, s_axis_tvalid_i && s_axis_tready_o |=> st1_valid_q)
  `VP4_ASSERT(a_den_nonzero, st3_valid_q && st3_div_q |-> st3_den_q != '0)
  `VP4_ASSERT(a_stall_holds_tail, !pipe_en |=> $stable(sb_valid_q[DivLat-1]))
  `VP4_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> s_axis_tready_o)

endmodule
